### hdl/dsa_pkg.sv
`default_nettype none

package dsa_pkg;

    localparam int SLOT_COUNT_DEF = 256;

    localparam int ID_W    = 48;
    localparam int TAG_W   = 16;
    localparam int ENTRY_W = ID_W + TAG_W;
    localparam int CNT_W   = 9;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TAG_W-1:0] GEN_RESET = TAG_W'(1);

    localparam logic [1:0] CMD_REGISTER = 2'd0;
    localparam logic [1:0] CMD_SWEEP    = 2'd1;
    localparam logic [1:0] CMD_QUERY    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] vendor_id;
        logic [15:0] product_id;
        logic [7:0]  bus_number;
        logic [7:0]  device_address;
        logic [7:0]  query_slot;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       slot;
        logic [ID_W-1:0]  stored_identity;
        logic [CNT_W-1:0] removed_count;
    } t_out_item;

    // sequencer to scan head
    typedef struct packed {
        logic start;
        logic visit;
        logic finish;
    } t_scan_ctl;

endpackage

`default_nettype wire

### hdl/dsa_cell.sv
`default_nettype none

module dsa_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_shift,
    input  wire logic [dsa_pkg::ENTRY_W-1:0] i_shift_data,
    input  wire logic                       i_load,
    input  wire logic [dsa_pkg::ENTRY_W-1:0] i_load_data,
    output logic      [dsa_pkg::ENTRY_W-1:0] o_data
);

    logic [dsa_pkg::ENTRY_W-1:0] r_entry;
    logic [dsa_pkg::ENTRY_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_shift) begin
            n_entry = i_shift_data;
        end else if (i_load) begin
            n_entry = i_load_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_data = r_entry;

endmodule

`default_nettype wire

### hdl/dsa_head.sv
`default_nettype none

module dsa_head #(
    parameter int SLOT_COUNT = dsa_pkg::SLOT_COUNT_DEF,
    localparam int IW = $clog2(SLOT_COUNT)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire dsa_pkg::t_scan_ctl          i_ctl,
    input  wire dsa_pkg::t_in_item           i_item,
    input  wire logic [IW-1:0]               i_step,
    input  wire logic [dsa_pkg::ENTRY_W-1:0] i_entry,
    output logic      [dsa_pkg::ENTRY_W-1:0] o_entry,
    output logic                             o_wr_en,
    output logic      [IW-1:0]               o_wr_idx,
    output logic      [dsa_pkg::ENTRY_W-1:0] o_wr_data,
    output dsa_pkg::t_out_item               o_result
);

    localparam int CW = (IW > 8) ? IW : 8;

    logic [1:0]                    r_cmd;
    logic [dsa_pkg::ID_W-1:0]      r_ident;
    logic [7:0]                    r_qslot;
    logic [dsa_pkg::TAG_W-1:0]     r_gen;
    logic                          r_have_free;
    logic [IW-1:0]                 r_first_free;
    logic                          r_found;
    logic [IW-1:0]                 r_found_idx;
    logic [dsa_pkg::CNT_W-1:0]     r_count;
    logic [dsa_pkg::ID_W-1:0]      r_qid;

    logic [dsa_pkg::TAG_W-1:0]     n_gen;
    logic                          n_have_free;
    logic [IW-1:0]                 n_first_free;
    logic                          n_found;
    logic [IW-1:0]                 n_found_idx;
    logic [dsa_pkg::CNT_W-1:0]     n_count;
    logic [dsa_pkg::ID_W-1:0]      n_qid;

    logic [dsa_pkg::ID_W-1:0]      w_held;
    logic [dsa_pkg::TAG_W-1:0]     w_tag;
    logic                          w_qhit;
    logic [CW-1:0]                 w_slot_ext;

    assign w_held = i_entry[dsa_pkg::ID_W-1:0];
    assign w_tag  = i_entry[dsa_pkg::ENTRY_W-1:dsa_pkg::ID_W];
    assign w_qhit = (CW'(i_step) == CW'(r_qslot));

    // latch the command at accept
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_cmd   <= i_item.cmd;
            r_ident <= {i_item.vendor_id, i_item.product_id,
                        i_item.bus_number, i_item.device_address};
            r_qslot <= i_item.query_slot;
        end
    end

    always_comb begin
        o_entry      = i_entry;
        n_gen        = r_gen;
        n_have_free  = r_have_free;
        n_first_free = r_first_free;
        n_found      = r_found;
        n_found_idx  = r_found_idx;
        n_count      = r_count;
        n_qid        = r_qid;

        if (i_ctl.start) begin
            n_have_free  = 1'b0;
            n_first_free = '0;
            n_found      = 1'b0;
            n_found_idx  = '0;
            n_count      = '0;
            n_qid        = '0;
        end else if (i_ctl.visit) begin
            unique case (r_cmd)
                dsa_pkg::CMD_REGISTER: begin
                    if (!r_found) begin
                        if (w_held == '0 && !r_have_free) begin
                            n_have_free  = 1'b1;
                            n_first_free = i_step;
                        end else if (w_held == r_ident) begin
                            o_entry     = {r_gen, w_held};
                            n_found     = 1'b1;
                            n_found_idx = i_step;
                        end
                    end
                end
                dsa_pkg::CMD_SWEEP: begin
                    if (i_entry != '0 && w_tag != r_gen) begin
                        o_entry = '0;
                        if (r_count != dsa_pkg::COUNT_MAX) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                end
                dsa_pkg::CMD_QUERY: begin
                    if (w_qhit) begin
                        n_qid = w_held;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_ctl.finish && r_cmd == dsa_pkg::CMD_SWEEP) begin
            n_gen = r_gen + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen        <= dsa_pkg::GEN_RESET;
            r_have_free  <= 1'b0;
            r_first_free <= '0;
            r_found      <= 1'b0;
            r_found_idx  <= '0;
            r_count      <= '0;
            r_qid        <= '0;
        end else begin
            r_gen        <= n_gen;
            r_have_free  <= n_have_free;
            r_first_free <= n_first_free;
            r_found      <= n_found;
            r_found_idx  <= n_found_idx;
            r_count      <= n_count;
            r_qid        <= n_qid;
        end
    end

    // claim the first free slot once the table is back in place
    assign o_wr_en   = i_ctl.finish && (r_cmd == dsa_pkg::CMD_REGISTER)
                       && !r_found && r_have_free;
    assign o_wr_idx  = r_first_free;
    assign o_wr_data = {r_gen, r_ident};

    always_comb begin
        o_result   = '0;
        w_slot_ext = '0;
        unique case (r_cmd)
            dsa_pkg::CMD_REGISTER: begin
                if (r_found) begin
                    w_slot_ext = CW'(r_found_idx);
                end else if (r_have_free) begin
                    w_slot_ext = CW'(r_first_free);
                end
                o_result.status = (r_found || r_have_free) ? dsa_pkg::ST_OK
                                                           : dsa_pkg::ST_FULL;
                o_result.slot   = w_slot_ext[7:0];
            end
            dsa_pkg::CMD_SWEEP: begin
                o_result.removed_count = r_count;
            end
            dsa_pkg::CMD_QUERY: begin
                o_result.status          = (r_qid == '0) ? dsa_pkg::ST_EMPTY
                                                         : dsa_pkg::ST_OK;
                o_result.stored_identity = r_qid;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/device_id_slot_allocator_unit.sv
// Each accepted item rotates the slot table once through the cell chain, one slot past
// the scan head per cycle; its result is registered once the output register is free.
// A new item is taken only after the scan of the previous one has finished; the output
// register lets the next item in while a result waits.
// Reset (synchronous, active low) clears every slot and sets the generation to 1.
`default_nettype none

module device_id_slot_allocator_unit #(
    parameter int SLOT_COUNT = dsa_pkg::SLOT_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire dsa_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output dsa_pkg::t_out_item      o_out_item
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [IW-1:0]      r_step;
    logic [IW-1:0]      n_step;
    logic               r_out_valid;
    logic               n_out_valid;
    dsa_pkg::t_out_item r_out_item;

    dsa_pkg::t_scan_ctl w_ctl;
    dsa_pkg::t_out_item w_result;
    logic               w_wr_en;
    logic [IW-1:0]      w_wr_idx;
    logic [dsa_pkg::ENTRY_W-1:0] w_wr_data;
    logic [dsa_pkg::ENTRY_W-1:0] w_head_out;
    logic [dsa_pkg::ENTRY_W-1:0] w_entry [SLOT_COUNT];

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        w_ctl.start  = 1'b0;
        w_ctl.visit  = 1'b0;
        w_ctl.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_ctl.start = 1'b1;
                    n_step      = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                w_ctl.visit = 1'b1;
                n_step      = r_step + 1'b1;
                if (r_step == LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    w_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_ctl.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.finish) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    dsa_head #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_head (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_item    (i_in_item),
        .i_step    (r_step),
        .i_entry   (w_entry[0]),
        .o_entry   (w_head_out),
        .o_wr_en   (w_wr_en),
        .o_wr_idx  (w_wr_idx),
        .o_wr_data (w_wr_data),
        .o_result  (w_result)
    );

    // cell 0 feeds the head, the head feeds the last cell
    for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
        logic [dsa_pkg::ENTRY_W-1:0] w_shift_in;
        if (k == SLOT_COUNT - 1) begin : g_tail
            assign w_shift_in = w_head_out;
        end else begin : g_mid
            assign w_shift_in = w_entry[k+1];
        end
        dsa_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (w_ctl.visit),
            .i_shift_data (w_shift_in),
            .i_load       (w_wr_en && (w_wr_idx == IW'(k))),
            .i_load_data  (w_wr_data),
            .o_data       (w_entry[k])
        );
    end

endmodule

`default_nettype wire

### hdl/dsa_checker.sv
`default_nettype none

module dsa_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire dsa_pkg::t_out_item o_out_item
);

    logic w_in_acc;
    logic w_full;

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_full   = (o_out_item.status == dsa_pkg::ST_FULL);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result dropped or changed while stalled");

    // a result of the previous item may still wait in the output register
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("item taken right after accept");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status == dsa_pkg::ST_OK ||
                         o_out_item.status == dsa_pkg::ST_FULL ||
                         o_out_item.status == dsa_pkg::ST_EMPTY))
        else $error("status code out of range");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != dsa_pkg::ST_OK
        |-> o_out_item.removed_count == '0 && o_out_item.stored_identity == '0)
        else $error("failed item carries data");

    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && w_full |-> o_out_item.slot == '0)
        else $error("full table reports a slot");

endmodule

bind device_id_slot_allocator_unit dsa_checker u_dsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

### tb/slot_table_checker.sv
`default_nettype none

module slot_table_checker #(
    parameter int SLOT_COUNT = dsa_pkg::SLOT_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire dsa_pkg::t_in_item  i_in_item,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire dsa_pkg::t_out_item i_out_item,
    output int                      o_fail_count,
    output int                      o_pending
);
    import dsa_pkg::*;

    localparam int REPORT_MAX = 10;

    logic [ENTRY_W-1:0] slot_mem [SLOT_COUNT];
    logic [TAG_W-1:0]   cur_gen;
    t_out_item          answers_due [$];
    int                 fail_cnt;

    // Apply one item to the shadow table and return the answer it produces.
    function automatic t_out_item predict_answer(input t_in_item it);
        t_out_item        ans;
        logic [ID_W-1:0]  ident;
        logic [ID_W-1:0]  held;
        int               first_free;
        int               found;
        bit               have_free;
        bit               hit;
        logic [CNT_W-1:0] cleared;
        ans        = '0;
        first_free = 0;
        found      = 0;
        have_free  = 1'b0;
        hit        = 1'b0;
        cleared    = '0;
        ident      = {it.vendor_id, it.product_id, it.bus_number, it.device_address};
        case (it.cmd)
            CMD_REGISTER: begin
                // a free slot after the first one still matches an all-zero identity
                for (int i = 0; i < SLOT_COUNT && !hit; i++) begin
                    held = slot_mem[i][ID_W-1:0];
                    if (held == '0 && !have_free) begin
                        have_free  = 1'b1;
                        first_free = i;
                    end else if (held == ident) begin
                        slot_mem[i] = {cur_gen, held};
                        found       = i;
                        hit         = 1'b1;
                    end
                end
                if (!hit) begin
                    if (have_free) begin
                        slot_mem[first_free] = {cur_gen, ident};
                        found                = first_free;
                    end else begin
                        ans.status = ST_FULL;
                    end
                end
                ans.slot = found[7:0];
            end
            CMD_SWEEP: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (slot_mem[i] != '0 && slot_mem[i][ENTRY_W-1:ID_W] != cur_gen) begin
                        slot_mem[i] = '0;
                        if (cleared != COUNT_MAX) cleared = cleared + 1'b1;
                    end
                end
                cur_gen           = cur_gen + 1'b1;
                ans.removed_count = cleared;
            end
            CMD_QUERY: begin
                held = '0;
                if (int'(it.query_slot) < SLOT_COUNT) held = slot_mem[it.query_slot][ID_W-1:0];
                if (held == '0) ans.status = ST_EMPTY;
                else ans.stored_identity = held;
            end
            default: begin
                ans = '0;
            end
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) slot_mem[i] = '0;
            cur_gen = GEN_RESET;
            answers_due.delete();
        end else begin
            // retire the result first: it can never belong to an item taken at this edge
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    if (fail_cnt < REPORT_MAX)
                        $display("unexpected result: status %0d slot %0d ident %h removed %0d",
                                 i_out_item.status, i_out_item.slot,
                                 i_out_item.stored_identity, i_out_item.removed_count);
                    fail_cnt++;
                end else begin
                    want = answers_due.pop_front();
                    if (want.status != i_out_item.status || want.slot != i_out_item.slot ||
                        want.stored_identity != i_out_item.stored_identity ||
                        want.removed_count != i_out_item.removed_count) begin
                        if (fail_cnt < REPORT_MAX)
                            $display("mismatch exp/got: status %0d/%0d slot %0d/%0d ident %h/%h removed %0d/%0d",
                                     want.status, i_out_item.status,
                                     want.slot, i_out_item.slot,
                                     want.stored_identity, i_out_item.stored_identity,
                                     want.removed_count, i_out_item.removed_count);
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) answers_due.push_back(predict_answer(i_in_item));
        end
        o_fail_count <= fail_cnt;
        o_pending    <= answers_due.size();
    end

endmodule

`default_nettype wire

### tb/device_id_slot_allocator_unit_tb.sv
`default_nettype none

module device_id_slot_allocator_unit_tb;
    import dsa_pkg::*;

    localparam int         SLOT_COUNT      = SLOT_COUNT_DEF;
    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam int         ITEM_TARGET     = 1850;
    localparam int         POOL_SIZE       = 24;
    localparam int         MIXED_LEN       = 50;
    localparam int         FILL_LEN        = SLOT_COUNT + 6;
    localparam int         HOLD_OFF_CYCLES = 2000;
    localparam int         DRAIN_LIMIT     = 20000;
    localparam int         RUN_LIMIT       = 25000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    int fail_count;
    int pending;
    int items_sent;
    int hold_off_req;
    bit steady;

    logic [ID_W-1:0] id_pool [POOL_SIZE];

    device_id_slot_allocator_unit #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    slot_table_checker #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        if (steady) return 0;
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [ID_W-1:0] rand_ident();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // fields that the command ignores carry random bits
    function automatic t_in_item make_item(input logic [1:0] cmd, input logic [ID_W-1:0] ident,
                                           input logic [7:0] qslot);
        t_in_item it;
        it.cmd            = cmd;
        it.query_slot     = (cmd == CMD_QUERY) ? qslot : 8'($urandom);
        {it.vendor_id, it.product_id, it.bus_number, it.device_address} =
            (cmd == CMD_REGISTER) ? ident : rand_ident();
        return it;
    endfunction

    task automatic push_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic put_register(input logic [ID_W-1:0] ident);
        push_item(make_item(CMD_REGISTER, ident, 8'd0));
    endtask

    task automatic put_query(input logic [7:0] qslot);
        push_item(make_item(CMD_QUERY, '0, qslot));
    endtask

    task automatic put_sweep();
        push_item(make_item(CMD_SWEEP, '0, 8'd0));
    endtask

    task automatic run_mixed();
        int pick;
        if ($urandom_range(0, 1) == 0)
            for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = rand_ident();
        repeat (MIXED_LEN) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) put_register(id_pool[$urandom_range(0, POOL_SIZE - 1)]);
            else if (pick < 58) put_register(rand_ident());
            else if (pick < 63) put_register('0);
            else if (pick < 83)
                put_query(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31)));
            else if (pick < 94) put_sweep();
            else push_item(make_item(CMD_UNUSED, '0, 8'd0));
        end
    endtask

    // Overfill the table, poke it while full, then sweep it clean.
    task automatic run_fill();
        for (int i = 0; i < FILL_LEN; i++) begin
            put_register(rand_ident());
            if (i % 20 == 0) put_query(8'($urandom));
        end
        put_register('0);
        put_register(id_pool[0]);
        put_register(rand_ident());
        put_query(8'(SLOT_COUNT - 1));
        put_sweep();
        put_sweep();
    endtask

    // receiver: random ready gaps, plus an occasional long hold-off
    initial begin : rx_side
        int wait_cycles;
        int hold_off_seen;
        out_ready     = 1'b0;
        hold_off_seen = 0;
        forever begin
            wait_cycles = pick_gap();
            if (hold_off_req != hold_off_seen) begin
                hold_off_seen = hold_off_req;
                wait_cycles   = wait_cycles + HOLD_OFF_CYCLES;
            end
            if (wait_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin : stim
        int phase;
        int guard;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        items_sent   = 0;
        hold_off_req = 0;
        steady       = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = rand_ident();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queries, extreme identities, zero identity matching a later free slot,
        // refresh across sweeps, unused command
        put_query(8'd0);
        put_query(8'hFF);
        put_register({ID_W{1'b1}});
        put_register(48'h0000_0000_0001);
        put_register('0);
        put_register({ID_W{1'b1}});
        put_query(8'd0);
        put_query(8'd1);
        put_query(8'd3);
        push_item(make_item(CMD_UNUSED, '0, 8'd0));
        put_sweep();
        put_register(48'h0000_0000_0001);
        put_register('0);
        put_sweep();
        put_query(8'd0);
        put_register(48'h8000_0000_0000);
        put_register(48'hA5A5_5A5A_A55A);
        put_sweep();
        put_query(8'd2);
        put_sweep();

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            steady = ($urandom_range(0, 3) == 0);
            if (phase == 2 || phase == 7) hold_off_req++;
            if (phase % 5 == 1) run_fill();
            else run_mixed();
            phase++;
        end
        in_valid <= 1'b0;

        @(posedge clk);
        guard = 0;
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (SLOT_COUNT + 8) @(posedge clk);

        if (fail_count == 0 && pending == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
